// File: design/aoc_pkg.sv
package aoc_pkg;

  localparam int ADDR_W          = 32;
  localparam int COUNT_W         = 16;
  localparam int RANK_W          = 7;
  localparam int STATUS_W        = 2;
  localparam int USED_OUT_W      = 8;
  localparam int DEFAULT_ENTRIES = 128;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 64;
  localparam int M_FIELDS_W = ADDR_W + COUNT_W + 1 + USED_OUT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic FUNC_SEE  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_NEW     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_COUNTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_READ    = 2'd3;

  typedef struct packed {
    logic capture;
    logic see;
    logic inc;
    logic insert;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

// File: design/aoc_cell.sv
module aoc_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  aoc_pkg::cell_ctl_t                ctl,
  input  logic [aoc_pkg::ADDR_W-1:0]        key,
  input  logic [aoc_pkg::RANK_W-1:0]        rank,
  input  logic [aoc_pkg::ADDR_W-1:0]        left_addr,
  input  logic [aoc_pkg::COUNT_W-1:0]       left_count,
  input  logic                              left_valid,
  input  logic                              left_lt,
  output logic [aoc_pkg::ADDR_W-1:0]        addr,
  output logic [aoc_pkg::COUNT_W-1:0]       count,
  output logic                              valid,
  output logic                              lt,
  output logic                              sel,
  output logic [aoc_pkg::ADDR_W-1:0]        sel_addr,
  output logic [aoc_pkg::COUNT_W-1:0]       sel_count
);

  logic load_key;
  logic shift;

  assign load_key = ctl.insert && !lt && left_lt;
  assign shift    = ctl.insert && !lt && !left_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      sel   <= 1'b0;
    end else begin
      if (ctl.capture) begin
        lt <= valid && (addr < key);
        if (ctl.see) begin
          sel <= valid && (addr == key);
        end else begin
          sel <= valid && (int'(rank) == INDEX);
        end
      end
      if (load_key) begin
        valid <= 1'b1;
      end else if (shift) begin
        valid <= left_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_key) begin
      addr  <= key;
      count <= aoc_pkg::COUNT_ONE;
    end else if (shift) begin
      addr  <= left_addr;
      count <= left_count;
    end else if (ctl.inc && sel && count != aoc_pkg::COUNT_MAX) begin
      count <= count + aoc_pkg::COUNT_ONE;
    end
  end

  assign sel_addr  = sel ? addr : '0;
  assign sel_count = sel ? count : '0;

endmodule

// File: design/address_occurrence_counter.sv
// Counts occurrences of distinct 32-bit addresses in a table of ENTRIES
// (2 to 128) cells kept in ascending address order. In the accept cycle
// all cells compare the address (or their rank) at once. In the update,
// which waits until the output register is free, a hit bumps the matching
// cell's saturating count, a miss shifts the higher cells up one place to
// open a slot unless the table is full, a read changes nothing, and the
// result goes to the output register. A new transaction is accepted only
// after the previous one's update, even while that result still waits in
// the output register, but its own update waits until that result is taken.
module address_occurrence_counter #(
  parameter int ENTRIES = aoc_pkg::DEFAULT_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [aoc_pkg::S_TDATA_W-1:0]   s_tdata,  // address[31:0], rank[38:32]
  input  logic                            s_tuser,  // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [aoc_pkg::M_TDATA_W-1:0]   m_tdata,  // entry_address, entry_count,
                                                    // entry_valid, entries_used
  output logic [aoc_pkg::STATUS_W-1:0]    m_tuser   // status
);

  localparam int USED_W = $clog2(ENTRIES + 1);

  aoc_pkg::state_t                     state;
  aoc_pkg::cell_ctl_t                  ctl;
  logic [USED_W-1:0]                   used;
  logic                                func_q;
  logic [aoc_pkg::ADDR_W-1:0]          key_q;
  logic [aoc_pkg::RANK_W-1:0]          rank_q;
  logic [aoc_pkg::ADDR_W-1:0]          key;
  logic [aoc_pkg::RANK_W-1:0]          rank;
  logic                                go;
  logic                                hit;
  logic                                full;

  logic [aoc_pkg::ADDR_W-1:0]          addr_v      [ENTRIES];
  logic [aoc_pkg::COUNT_W-1:0]         count_v     [ENTRIES];
  logic [aoc_pkg::ADDR_W-1:0]          sel_addr_v  [ENTRIES];
  logic [aoc_pkg::COUNT_W-1:0]         sel_count_v [ENTRIES];
  logic [ENTRIES-1:0]                  valid_v;
  logic [ENTRIES-1:0]                  lt_v;
  logic [ENTRIES-1:0]                  sel_v;

  logic [aoc_pkg::ADDR_W-1:0]          sel_addr;
  logic [aoc_pkg::COUNT_W-1:0]         sel_count;

  logic [aoc_pkg::STATUS_W-1:0]        res_status;
  logic [aoc_pkg::ADDR_W-1:0]          res_addr;
  logic [aoc_pkg::COUNT_W-1:0]         res_count;
  logic                                res_valid;
  logic [USED_W-1:0]                   used_next;

  assign s_tready = (state == aoc_pkg::ST_IDLE);
  assign go       = (state == aoc_pkg::ST_EXEC) && (!m_tvalid || m_tready);
  assign hit      = |sel_v;
  assign full     = (used == USED_W'(ENTRIES));
  assign key      = s_tready ? s_tdata[31:0] : key_q;
  assign rank     = s_tready ? s_tdata[38:32] : rank_q;

  assign ctl.capture = s_tvalid && s_tready;
  assign ctl.see     = (s_tuser == aoc_pkg::FUNC_SEE);
  assign ctl.inc     = go && (func_q == aoc_pkg::FUNC_SEE) && hit;
  assign ctl.insert  = go && (func_q == aoc_pkg::FUNC_SEE) && !hit && !full;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [aoc_pkg::ADDR_W-1:0]  l_addr;
    logic [aoc_pkg::COUNT_W-1:0] l_count;
    logic                        l_valid;
    logic                        l_lt;

    if (g == 0) begin : g_head
      assign l_addr  = '0;
      assign l_count = '0;
      assign l_valid = 1'b0;
      assign l_lt    = 1'b1;
    end else begin : g_link
      assign l_addr  = addr_v[g-1];
      assign l_count = count_v[g-1];
      assign l_valid = valid_v[g-1];
      assign l_lt    = lt_v[g-1];
    end

    aoc_cell #(
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key),
      .rank       (rank),
      .left_addr  (l_addr),
      .left_count (l_count),
      .left_valid (l_valid),
      .left_lt    (l_lt),
      .addr       (addr_v[g]),
      .count      (count_v[g]),
      .valid      (valid_v[g]),
      .lt         (lt_v[g]),
      .sel        (sel_v[g]),
      .sel_addr   (sel_addr_v[g]),
      .sel_count  (sel_count_v[g])
    );
  end

  always_comb begin
    sel_addr  = '0;
    sel_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_addr  = sel_addr | sel_addr_v[i];
      sel_count = sel_count | sel_count_v[i];
    end
  end

  always_comb begin
    used_next  = used;
    res_addr   = key_q;
    res_count  = '0;
    res_valid  = 1'b0;
    res_status = aoc_pkg::STATUS_READ;
    if (func_q == aoc_pkg::FUNC_READ) begin
      res_addr  = sel_addr;
      res_count = sel_count;
      res_valid = hit;
    end else if (hit) begin
      res_status = aoc_pkg::STATUS_COUNTED;
      res_valid  = 1'b1;
      res_count  = (sel_count == aoc_pkg::COUNT_MAX) ? sel_count
                                                     : sel_count + aoc_pkg::COUNT_ONE;
    end else if (!full) begin
      res_status = aoc_pkg::STATUS_NEW;
      res_valid  = 1'b1;
      res_count  = aoc_pkg::COUNT_ONE;
      used_next  = used + USED_W'(1);
    end else begin
      res_status = aoc_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= aoc_pkg::ST_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        aoc_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            state <= aoc_pkg::ST_EXEC;
          end
        end
        aoc_pkg::ST_EXEC: begin
          if (go) begin
            state <= aoc_pkg::ST_IDLE;
          end
        end
        default: state <= aoc_pkg::ST_IDLE;
      endcase
      if (go) begin
        m_tvalid <= 1'b1;
        used     <= used_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      func_q <= s_tuser;
      key_q  <= s_tdata[31:0];
      rank_q <= s_tdata[38:32];
    end
    if (go) begin
      m_tuser <= res_status;
      m_tdata <= {(aoc_pkg::M_TDATA_W - aoc_pkg::M_FIELDS_W)'(0),
                  aoc_pkg::USED_OUT_W'(used_next), res_valid, res_count, res_addr};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl.insert |=> used == $past(used) + USED_W'(1))
    else $error("entry count did not follow an insert");

  assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_v) == int'(used))
    else $error("valid cells disagree with entry count");

  assert property (@(posedge clk) disable iff (rst)
    state == aoc_pkg::ST_EXEC |-> $onehot0(sel_v))
    else $error("more than one cell selected");

  assert property (@(posedge clk) disable iff (rst)
    go |=> m_tvalid)
    else $error("result not presented");

endmodule
